/* src/efws_pkg.sv */
// shared types and constants for the earliest-free worker scheduler
package efws_pkg;

    localparam int TIME_W            = 48;
    localparam int DUR_W             = 32;
    localparam int WIDX_W            = 4;
    localparam int CFG_W             = 5;
    localparam int MAX_WORKERS_DFLT  = 16;
    localparam logic [CFG_W-1:0] NUM_WORKERS_RST = CFG_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_HOLD
    } efws_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } efws_ctl_t;

endpackage

/* src/efws_cell.sv */
// one cell of the sorted free-time chain: pick on capture, remove and reinsert on commit
module efws_cell #(
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  efws_pkg::efws_ctl_t         ctl,
    input  logic [CNT_W-1:0]            n_eff,
    input  logic [efws_pkg::TIME_W-1:0] new_time,
    input  logic [IDX_W-1:0]            new_idx,
    // raw entry of the right neighbour
    input  logic [efws_pkg::TIME_W-1:0] right_time,
    input  logic [IDX_W-1:0]            right_idx,
    input  logic                        right_lt,
    output logic [efws_pkg::TIME_W-1:0] raw_time,
    output logic [IDX_W-1:0]            raw_idx,
    output logic                        raw_lt,
    // compacted entry of the left neighbour
    input  logic [efws_pkg::TIME_W-1:0] left_time,
    input  logic [IDX_W-1:0]            left_idx,
    input  logic                        left_lt,
    output logic [efws_pkg::TIME_W-1:0] comp_time,
    output logic [IDX_W-1:0]            comp_idx,
    output logic                        comp_lt,
    // selection chain
    input  logic                        found_in,
    output logic                        found_out,
    input  logic [efws_pkg::TIME_W-1:0] pick_time_in,
    input  logic [IDX_W-1:0]            pick_idx_in,
    output logic [efws_pkg::TIME_W-1:0] pick_time_out,
    output logic [IDX_W-1:0]            pick_idx_out
);

    logic [efws_pkg::TIME_W-1:0] time_reg;
    logic [efws_pkg::TIME_W-1:0] time_next;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            idx_next;
    logic                        past_reg;
    logic                        qual;
    logic                        sel;

    assign qual          = CNT_W'(idx_reg) < n_eff;
    assign sel           = qual & ~found_in;
    assign found_out     = found_in | sel;
    assign pick_time_out = pick_time_in | (sel ? time_reg : '0);
    assign pick_idx_out  = pick_idx_in | (sel ? idx_reg : '0);

    assign raw_time = time_reg;
    assign raw_idx  = idx_reg;
    assign raw_lt   = (time_reg < new_time) || ((time_reg == new_time) && (idx_reg < new_idx));

    // skip over the removed entry
    assign comp_time = past_reg ? right_time : time_reg;
    assign comp_idx  = past_reg ? right_idx : idx_reg;
    assign comp_lt   = past_reg ? right_lt : raw_lt;

    always_comb
    begin
        if (comp_lt)
        begin
            time_next = comp_time;
            idx_next  = comp_idx;
        end
        else if (left_lt)
        begin
            time_next = new_time;
            idx_next  = new_idx;
        end
        else
        begin
            time_next = left_time;
            idx_next  = left_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            idx_reg  <= IDX_W'(CELL_IDX);
            past_reg <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                past_reg <= found_out;
            end
            if (ctl.commit)
            begin
                time_reg <= time_next;
                idx_reg  <= idx_next;
            end
        end
    end

endmodule

/* src/efws_chain.sv */
// row of cells kept sorted by free time then worker index
module efws_chain #(
    parameter int MAX_WORKERS = efws_pkg::MAX_WORKERS_DFLT,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  efws_pkg::efws_ctl_t         ctl,
    input  logic [CNT_W-1:0]            n_eff,
    input  logic [efws_pkg::TIME_W-1:0] new_time,
    input  logic [IDX_W-1:0]            new_idx,
    output logic [efws_pkg::TIME_W-1:0] pick_time,
    output logic [IDX_W-1:0]            pick_idx
);

    logic [efws_pkg::TIME_W-1:0] raw_time  [MAX_WORKERS];
    logic [IDX_W-1:0]            raw_idx   [MAX_WORKERS];
    logic                        raw_lt    [MAX_WORKERS];
    logic [efws_pkg::TIME_W-1:0] comp_time [MAX_WORKERS];
    logic [IDX_W-1:0]            comp_idx  [MAX_WORKERS];
    logic                        comp_lt   [MAX_WORKERS];
    logic                        found     [MAX_WORKERS];
    logic [efws_pkg::TIME_W-1:0] ptime     [MAX_WORKERS];
    logic [IDX_W-1:0]            pidx      [MAX_WORKERS];

    for (genvar j = 0; j < MAX_WORKERS; j++)
    begin : g_cell
        logic [efws_pkg::TIME_W-1:0] r_time;
        logic [IDX_W-1:0]            r_idx;
        logic                        r_lt;
        logic [efws_pkg::TIME_W-1:0] l_time;
        logic [IDX_W-1:0]            l_idx;
        logic                        l_lt;
        logic                        f_in;
        logic [efws_pkg::TIME_W-1:0] p_time;
        logic [IDX_W-1:0]            p_idx;

        if (j == MAX_WORKERS - 1)
        begin : g_last
            assign r_time = '0;
            assign r_idx  = '0;
            assign r_lt   = 1'b0;
        end
        else
        begin : g_mid
            assign r_time = raw_time[j+1];
            assign r_idx  = raw_idx[j+1];
            assign r_lt   = raw_lt[j+1];
        end

        if (j == 0)
        begin : g_first
            assign l_time = '0;
            assign l_idx  = '0;
            assign l_lt   = 1'b1;
            assign f_in   = 1'b0;
            assign p_time = '0;
            assign p_idx  = '0;
        end
        else
        begin : g_next
            assign l_time = comp_time[j-1];
            assign l_idx  = comp_idx[j-1];
            assign l_lt   = comp_lt[j-1];
            assign f_in   = found[j-1];
            assign p_time = ptime[j-1];
            assign p_idx  = pidx[j-1];
        end

        efws_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (j)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .n_eff         (n_eff),
            .new_time      (new_time),
            .new_idx       (new_idx),
            .right_time    (r_time),
            .right_idx     (r_idx),
            .right_lt      (r_lt),
            .raw_time      (raw_time[j]),
            .raw_idx       (raw_idx[j]),
            .raw_lt        (raw_lt[j]),
            .left_time     (l_time),
            .left_idx      (l_idx),
            .left_lt       (l_lt),
            .comp_time     (comp_time[j]),
            .comp_idx      (comp_idx[j]),
            .comp_lt       (comp_lt[j]),
            .found_in      (f_in),
            .found_out     (found[j]),
            .pick_time_in  (p_time),
            .pick_idx_in   (p_idx),
            .pick_time_out (ptime[j]),
            .pick_idx_out  (pidx[j])
        );
    end

    assign pick_time = ptime[MAX_WORKERS-1];
    assign pick_idx  = pidx[MAX_WORKERS-1];

endmodule

/* src/earliest_free_worker_scheduler_unit.sv */
// top level of the earliest-free worker scheduler
// a transaction is picked in the idle state, then its worker is removed and reinserted in the
// insert state, where the result is registered; while the output stalls it waits in the hold
// state; a new transaction is taken only back in idle, so one is done before the next is taken
// reset: all free times zero, cells sorted by worker index, num_workers 16
module earliest_free_worker_scheduler_unit #(
    parameter int MAX_WORKERS = efws_pkg::MAX_WORKERS_DFLT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           num_workers_wr_en,
    input  logic [efws_pkg::CFG_W-1:0]     num_workers,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [efws_pkg::DUR_W-1:0]     job_duration,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [efws_pkg::WIDX_W-1:0]    worker_index,
    output logic [efws_pkg::TIME_W-1:0]    start_time
);

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);

    efws_pkg::efws_state_t       state_reg;
    efws_pkg::efws_state_t       state_next;
    efws_pkg::efws_ctl_t         ctl;
    logic                        load_out;
    logic [efws_pkg::CFG_W-1:0]  num_workers_reg;
    logic [CNT_W-1:0]            n_eff;
    logic [efws_pkg::TIME_W-1:0] pick_time;
    logic [IDX_W-1:0]            pick_idx;
    logic [efws_pkg::TIME_W:0]   sum;
    logic [efws_pkg::TIME_W-1:0] new_time_reg;
    logic [IDX_W-1:0]            new_idx_reg;
    logic [efws_pkg::TIME_W-1:0] start_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [efws_pkg::WIDX_W-1:0] worker_index_reg;
    logic [efws_pkg::TIME_W-1:0] start_time_reg;

    // clamp worker count to 1..MAX_WORKERS
    always_comb
    begin
        if (num_workers_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(num_workers_reg) > 32'(MAX_WORKERS))
        begin
            n_eff = CNT_W'(MAX_WORKERS);
        end
        else
        begin
            n_eff = CNT_W'(num_workers_reg);
        end
    end

    efws_chain #(
        .MAX_WORKERS (MAX_WORKERS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .n_eff     (n_eff),
        .new_time  (new_time_reg),
        .new_idx   (new_idx_reg),
        .pick_time (pick_time),
        .pick_idx  (pick_idx)
    );

    // saturating free-time update
    assign sum = {1'b0, pick_time} + (efws_pkg::TIME_W + 1)'(job_duration);

    always_comb
    begin
        state_next  = state_reg;
        ctl.capture = 1'b0;
        ctl.commit  = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            efws_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = efws_pkg::ST_INSERT;
                end
            end
            efws_pkg::ST_INSERT:
            begin
                ctl.commit = 1'b1;
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = efws_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = efws_pkg::ST_HOLD;
                end
            end
            efws_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = efws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = efws_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= efws_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            num_workers_reg <= efws_pkg::NUM_WORKERS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (num_workers_wr_en)
            begin
                num_workers_reg <= num_workers;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            new_time_reg <= sum[efws_pkg::TIME_W] ? '1 : sum[efws_pkg::TIME_W-1:0];
            new_idx_reg  <= pick_idx;
            start_reg    <= pick_time;
        end
        if (load_out)
        begin
            worker_index_reg <= efws_pkg::WIDX_W'(new_idx_reg);
            start_time_reg   <= start_reg;
        end
    end

    assign in_stall     = (state_reg != efws_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign worker_index = worker_index_reg;
    assign start_time   = start_time_reg;

endmodule

/* dv/earliest_free_worker_scheduler_unit_test.sv */
// testbench for the earliest-free worker scheduler: directed, random, long-job and stall tests
module earliest_free_worker_scheduler_unit_test;

    localparam int LATENCY          = 2;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct {
        logic [efws_pkg::WIDX_W-1:0] worker;
        logic [efws_pkg::TIME_W-1:0] start;
    } assignment_t;

    logic                        clk               = 1'b0;
    logic                        rst_n             = 1'b0;
    logic                        num_workers_wr_en = 1'b0;
    logic [efws_pkg::CFG_W-1:0]  num_workers       = '0;
    logic                        in_valid          = 1'b0;
    logic                        in_stall;
    logic [efws_pkg::DUR_W-1:0]  job_duration      = '0;
    logic                        out_valid;
    logic                        out_stall         = 1'b0;
    logic [efws_pkg::WIDX_W-1:0] worker_index;
    logic [efws_pkg::TIME_W-1:0] start_time;

    logic [efws_pkg::TIME_W-1:0] free_times [efws_pkg::MAX_WORKERS_DFLT];
    logic [efws_pkg::CFG_W-1:0]  worker_count = efws_pkg::NUM_WORKERS_RST;
    assignment_t                 due_assignments [$];
    assignment_t                 oldest;
    int                          mismatch_count = 0;

    int unsigned       tx_idle_pct  = 10;
    int unsigned       rx_stall_pct = 49;
    logic              hold_toggle  = 1'b0;
    logic              hold_seen    = 1'b0;
    int                hold_left    = 0;

    earliest_free_worker_scheduler_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .num_workers_wr_en (num_workers_wr_en),
        .num_workers       (num_workers),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .job_duration      (job_duration),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .worker_index      (worker_index),
        .start_time        (start_time)
    );

    always #6 clk = ~clk;

    initial
    begin
        foreach (free_times[i])
        begin
            free_times[i] = '0;
        end
    end

    // earliest free worker among those in use, lowest index on a tie
    function automatic assignment_t assign_job(input logic [efws_pkg::DUR_W-1:0] dur);
        assignment_t                 a;
        int                          n;
        int                          best;
        logic [efws_pkg::TIME_W:0]   sum;
        n = (worker_count == 0) ? 1 :
            ((worker_count > efws_pkg::MAX_WORKERS_DFLT) ?
             efws_pkg::MAX_WORKERS_DFLT : int'(worker_count));
        best = 0;
        for (int i = 1; i < n; i++)
        begin
            if (free_times[i] < free_times[best])
                best = i;
        end
        a.worker = efws_pkg::WIDX_W'(best);
        a.start  = free_times[best];
        sum = {1'b0, free_times[best]} + (efws_pkg::TIME_W + 1)'(dur);
        free_times[best] = sum[efws_pkg::TIME_W] ? {efws_pkg::TIME_W{1'b1}} :
                           sum[efws_pkg::TIME_W-1:0];
        return a;
    endfunction

    function automatic void report_mismatch(input string field,
                                            input logic [efws_pkg::TIME_W-1:0] want,
                                            input logic [efws_pkg::TIME_W-1:0] got);
        mismatch_count++;
        $error("%s mismatch: expected %0h, actual %0h", field, want, got);
    endfunction

    function automatic logic [efws_pkg::DUR_W-1:0] random_duration();
        case ($urandom_range(3))
            0:       return efws_pkg::DUR_W'($urandom_range(15));
            1:       return efws_pkg::DUR_W'($urandom);
            2:       return efws_pkg::DUR_W'($urandom_range(1000));
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_assignments.size() == 0)
            begin
                mismatch_count++;
                $error("unexpected transaction: worker_index %0d start_time %0h",
                       worker_index, start_time);
            end
            else
            begin
                oldest = due_assignments.pop_front();
                if (worker_index !== oldest.worker)
                    report_mismatch("worker_index", efws_pkg::TIME_W'(oldest.worker),
                                    efws_pkg::TIME_W'(worker_index));
                if (start_time !== oldest.start)
                    report_mismatch("start_time", oldest.start, start_time);
            end
        end
    end

    task automatic send_job(input logic [efws_pkg::DUR_W-1:0] dur);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        job_duration <= dur;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        due_assignments.push_back(assign_job(dur));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (due_assignments.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_worker_count(input logic [efws_pkg::CFG_W-1:0] count);
        wait_for_results();
        repeat (LATENCY + 1) @(posedge clk);
        num_workers       <= count;
        num_workers_wr_en <= 1'b1;
        @(posedge clk);
        num_workers_wr_en <= 1'b0;
        worker_count = count;
    endtask

    task automatic test_directed();
        send_job('0);
        send_job('1);
        send_job(efws_pkg::DUR_W'(5));
        send_job('0);
        send_job(efws_pkg::DUR_W'(7));
        // zero count behaves as a single worker
        set_worker_count('0);
        send_job(efws_pkg::DUR_W'(3));
        // counts above the built size behave as the full size
        set_worker_count(efws_pkg::CFG_W'(31));
        send_job('0);
        set_worker_count(efws_pkg::CFG_W'(17));
        send_job(efws_pkg::DUR_W'(9));
        // narrowing the count keeps the free times of the others
        set_worker_count(efws_pkg::CFG_W'(2));
        send_job(efws_pkg::DUR_W'(1));
        set_worker_count(efws_pkg::CFG_W'(1));
        send_job('0);
        set_worker_count(efws_pkg::CFG_W'(16));
        repeat (12) send_job('1);
    endtask

    task automatic test_random();
        int unsigned                tx_pct [3]   = '{10, 49, 0};
        int unsigned                rx_pct [3]   = '{49, 10, 0};
        logic [efws_pkg::CFG_W-1:0] extremes [6] = '{1, 16, 0, 31, 17, 2};
        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct  = tx_pct[p];
            rx_stall_pct = rx_pct[p];
            for (int c = 0; c < 6; c++)
            begin
                if (c % 2 == 0)
                    set_worker_count(extremes[(3 * p + c / 2) % 6]);
                else
                    set_worker_count(efws_pkg::CFG_W'($urandom_range(31)));
                repeat (56) send_job(random_duration());
            end
        end
    endtask

    // one worker fed the longest jobs, then a second worker joins
    task automatic test_long_jobs();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        set_worker_count(efws_pkg::CFG_W'(1));
        repeat (40) send_job('1);
        set_worker_count(efws_pkg::CFG_W'(2));
        repeat (4) send_job('1);
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 10;
        set_worker_count(efws_pkg::CFG_W'(16));
        hold_toggle <= ~hold_toggle;
        repeat (24) send_job(random_duration());
        wait_for_results();
        repeat (40) send_job(random_duration());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        test_long_jobs();
        test_backpressure();
        wait_for_results();
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
